// ----- rtl/lpht_pkg.sv -----
package lpht_pkg;

  localparam int TABLE_SIZE = 128;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int N_W        = IDX_W + 1;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 8;

  localparam int DIGIT_W    = 4;
  localparam int MOD_STEPS  = (KEY_W + DIGIT_W) / DIGIT_W;
  localparam int PAD_W      = MOD_STEPS * DIGIT_W;
  localparam int MSTEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(128);

  localparam logic REG_SLOTS_IN_USE = 1'b0;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

// ----- rtl/lpht_in_if.sv -----
interface lpht_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [lpht_pkg::KEY_W-1:0]      key;
  logic signed [lpht_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

// ----- rtl/lpht_out_if.sv -----
interface lpht_out_if;
  logic                              valid;
  logic                              ready;
  logic [lpht_pkg::STATUS_W-1:0]     status;
  logic signed [lpht_pkg::VAL_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

// ----- rtl/linear_probe_hash_table_top.sv -----
// Channel  Direction  Payload                              Handshake
// in_ch    sink       kind[0], key[30:0], value[31:0]       valid/ready
// out_ch   source     status[1:0], read_value[31:0]         valid/ready
// cfg      APB slave  slots_in_use at byte address 0        psel/penable/pready
//
// One transaction at a time: accept, then key modulo slot count (4 key bits a
// cycle), then per probe a memory read and a compare.
// The number of probes for an item is at most the slot count.
// Reset (rst_n low, synchronous) clears all valid bits at once; no clearing pass.
// A result waits in the output register; a following item is accepted meanwhile
// and stalls in its compare cycle only while that register is still full.
module linear_probe_hash_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  lpht_in_if.sink                        in_ch,
  lpht_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpht_pkg::ADDR_W-1:0]    paddr,
  input  logic [lpht_pkg::DATA_W-1:0]    pwdata,
  output logic [lpht_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import lpht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      slots_r;
  logic [N_W-1:0]        n_w;

  logic                  kind_r;
  logic [KEY_W-1:0]      key_r;
  logic [VAL_W-1:0]      value_r;
  logic [PAD_W-1:0]      key_sh_r, key_sh_nxt;
  logic [MSTEP_W-1:0]    mstep_r, mstep_nxt;
  logic [N_W-1:0]        rem_r, rem_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [N_W-1:0]        cnt_r, cnt_nxt;

  slot_t                 mem [TABLE_SIZE];
  slot_t                 rd_data_r;
  logic [TABLE_SIZE-1:0] slot_valid_r;
  logic                  vld_q_r;
  logic                  mem_re, mem_we;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r, status_w;
  logic [VAL_W-1:0]      out_value_r, rdval_w;

  logic                  accept_w, cfg_we;
  logic                  hit_w, stop_w, last_w, fin_w, out_free_w, commit_w;
  logic [N_W-1:0]        idx_inc_w;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SLOTS_IN_USE);
  assign prdata = (paddr[ADDR_W-1] == REG_SLOTS_IN_USE) ?
                  DATA_W'(slots_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else if (cfg_we) begin
      slots_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (slots_r == '0) begin
      n_w = N_W'(1);
    end else if (N_W'(slots_r) > N_W'(TABLE_SIZE) || CFG_W > N_W) begin
      n_w = (32'(slots_r) > TABLE_SIZE) ? N_W'(TABLE_SIZE) : N_W'(slots_r);
    end else begin
      n_w = N_W'(slots_r);
    end
  end

  // handshake
  assign in_ch.ready       = (state_r == S_IDLE);
  assign accept_w          = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_value_r;

  // probe compare
  assign hit_w      = vld_q_r && (rd_data_r.key == key_r);
  assign stop_w     = !vld_q_r || hit_w;
  assign last_w     = (cnt_r + N_W'(1)) == n_w;
  assign fin_w      = stop_w || last_w;
  assign out_free_w = !out_valid_r || out_ch.ready;
  assign commit_w   = (state_r == S_CHK) && fin_w && out_free_w;
  assign mem_we     = commit_w && (kind_r == KIND_INSERT) && stop_w;
  assign mem_re     = (state_r == S_RD);
  assign idx_inc_w  = N_W'(idx_r) + N_W'(1);

  always_comb begin
    rdval_w = '0;
    if (kind_r == KIND_LOOKUP) begin
      status_w = hit_w ? ST_HIT : ST_MISS;
      if (hit_w) begin
        rdval_w = rd_data_r.value;
      end
    end else if (!stop_w) begin
      status_w = ST_FULL;
    end else begin
      status_w = vld_q_r ? ST_HIT : ST_NEW;
    end
  end

  // control
  always_comb begin
    state_nxt  = state_r;
    key_sh_nxt = key_sh_r;
    mstep_nxt  = mstep_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept_w) begin
          key_sh_nxt = PAD_W'(in_ch.key);
          mstep_nxt  = '0;
          rem_nxt    = '0;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        for (int i = 0; i < DIGIT_W; i++) begin
          rem_nxt = {rem_nxt[N_W-2:0], key_sh_r[PAD_W-1-i]};
          if (rem_nxt >= n_w) begin
            rem_nxt = rem_nxt - n_w;
          end
        end
        key_sh_nxt = key_sh_r << DIGIT_W;
        mstep_nxt  = mstep_r + MSTEP_W'(1);
        if (mstep_r == MSTEP_W'(MOD_STEPS - 1)) begin
          idx_nxt   = rem_nxt[IDX_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!fin_w) begin
          cnt_nxt   = cnt_r + N_W'(1);
          idx_nxt   = (idx_inc_w >= n_w) ? '0 : idx_inc_w[IDX_W-1:0];
          state_nxt = S_RD;
        end else if (out_free_w) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w) begin
      kind_r  <= in_ch.kind;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
    key_sh_r <= key_sh_nxt;
    mstep_r  <= mstep_nxt;
    rem_r    <= rem_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= '{key: key_r, value: value_r};
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_r];
      vld_q_r   <= slot_valid_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (mem_we) begin
      slot_valid_r[idx_r] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_w) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_w) begin
      out_status_r <= status_w;
      out_value_r  <= rdval_w;
    end
  end

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (cnt_r < n_w))
    else $error("probe count reached slot count");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (N_W'(idx_r) < n_w))
    else $error("probe index outside slots in use");

  a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (kind_r == KIND_INSERT) && (state_r == S_CHK) && out_free_w)
    else $error("slot write outside insert commit");

  a_out_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CHK))
    else $error("result raised without a finished probe");

endmodule
